/* rtl/bdc_pkg.sv */
package bdc_pkg;

	// configuration port
	localparam int APB_DW = 32;
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_RESET = 4'd3;
	localparam logic [PC_W-1:0] PC_MIN = 4'd2;
	localparam logic REG_POINT_COUNT = 1'b0;

	// request codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// per-cell control, shared by the whole chain except ins
	typedef struct packed {
		logic load;
		logic step;
		logic first;
		logic ins;
	} cell_ctrl_t;

endpackage

/* rtl/bdc_lerp.sv */
module bdc_lerp #(
	parameter int PT_W = 20,
	parameter int T_BITS = 16
) (
	input  logic [PT_W-1:0] a,
	input  logic [PT_W-1:0] b,
	input  logic [T_BITS:0] t,
	output logic [PT_W-1:0] q
);

	localparam int PW = PT_W + T_BITS + 3;
	localparam logic signed [PW-1:0] HALF = PW'(1) <<< (T_BITS - 1);

	logic signed [PT_W:0]   diff;
	logic signed [PW-1:0]   diff_ext;
	logic signed [PW-1:0]   t_ext;
	logic signed [PW-1:0]   prod;
	logic signed [PW-1:0]   shifted;
	logic        [PT_W+1:0] sum;

	always_comb begin
		diff     = $signed({1'b0, b}) - $signed({1'b0, a});
		diff_ext = PW'(diff);
		t_ext    = $signed(PW'({1'b0, t}));
		prod     = t_ext * diff_ext;
		// arithmetic shift floors, so ties go toward plus infinity
		shifted  = (prod + HALF) >>> T_BITS;
		sum      = {2'b00, a} + shifted[PT_W+1:0];
		q        = sum[PT_W-1:0];
	end

endmodule

/* rtl/bdc_cell.sv */
module bdc_cell
	import bdc_pkg::*;
#(
	parameter int PT_W = 20
) (
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic [2*PT_W-1:0] ld,
	input  logic [2*PT_W-1:0] nb1,
	input  logic [2*PT_W-1:0] nb2,
	input  logic [2*PT_W-1:0] res,
	output logic [2*PT_W-1:0] pt
);

	logic [2*PT_W-1:0] pt_q;

	// first step of a level skips the stale head, so it moves by two
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			pt_q <= ld;
		end else if (ctrl.step) begin
			if (ctrl.ins) begin
				pt_q <= res;
			end else if (ctrl.first) begin
				pt_q <= nb2;
			end else begin
				pt_q <= nb1;
			end
		end
	end

	assign pt = pt_q;

endmodule

/* rtl/bezier_de_casteljau_eval_unit.sv */
// de casteljau bezier evaluator, n = point_count clamped to [2, MAX_POINTS]
// load request: stored on the transfer edge, no result
// evaluate: first point valid once the chain is loaded and the output register fills, then one point a cycle
// while out_stall is low; n(n-1)/2 points, next request taken in the cycle after the last step
// at eight points: 28 points per evaluation, one per step from the single shared lerp pair
// reset: point_count back to 3, control idle, output empty; point store undefined until loaded
module bezier_de_casteljau_eval_unit
	import bdc_pkg::*;
#(
	parameter int MAX_POINTS = 8,
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS = 8,
	parameter int T_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [APB_DW-1:0]             pwdata,
	output logic [APB_DW-1:0]             prdata,
	output logic                          pready,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [$clog2(MAX_POINTS)-1:0] point_index,
	input  logic [COORD_BITS-1:0]         coord_x,
	input  logic [COORD_BITS-1:0]         coord_y,
	input  logic [T_BITS:0]               t_param,
	// point channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [$clog2(MAX_POINTS)-1:0] level,
	output logic [$clog2(MAX_POINTS)-1:0] position,
	output logic [COORD_BITS+FRAC_BITS-1:0] point_x,
	output logic [COORD_BITS+FRAC_BITS-1:0] point_y,
	output logic                          last
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int LVL_W = IDX_W;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int PT_W = COORD_BITS + FRAC_BITS;
	// cell 0 holds the stale head of each level, the points follow it
	localparam int NCELL = MAX_POINTS + 1;
	localparam logic [T_BITS:0] T_ONE = {1'b1, {T_BITS{1'b0}}};

	// configuration
	logic [PC_W-1:0]  pc_q;
	logic [CNT_W-1:0] n_sat;

	// point store, payload only
	logic [COORD_BITS-1:0] store_x_q [MAX_POINTS];
	logic [COORD_BITS-1:0] store_y_q [MAX_POINTS];

	// sequencer
	state_t           state_q, state_d;
	logic [LVL_W-1:0] cur_level_q;
	logic [LVL_W-1:0] len_q;
	logic [LVL_W-1:0] step_q;
	logic [T_BITS:0]  t_q;
	logic             in_xfer;
	logic             eval_go;
	logic             load_go;
	logic             advance;
	logic             level_end;
	logic             first;

	// chain and lerp
	logic [2*PT_W-1:0] cell_pt [NCELL];
	logic [2*PT_W-1:0] a_pt;
	logic [2*PT_W-1:0] b_pt;
	logic [PT_W-1:0]   qx;
	logic [PT_W-1:0]   qy;

	// output register
	logic             out_valid_q;
	logic [LVL_W-1:0] out_level_q;
	logic [LVL_W-1:0] out_pos_q;
	logic [PT_W-1:0]  out_x_q;
	logic [PT_W-1:0]  out_y_q;
	logic             out_last_q;

	// ---------------------------------------------------------------
	// configuration register, paddr[2] picks the register word
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_POINT_COUNT)) begin
			pc_q <= pwdata[PC_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_POINT_COUNT) ? {{(APB_DW-PC_W){1'b0}}, pc_q} : '0;

	// curve order in use, clamped into the supported range
	always_comb begin
		if (pc_q < PC_MIN) begin
			n_sat = CNT_W'(PC_MIN);
		end else if (pc_q > PC_W'(MAX_POINTS)) begin
			n_sat = CNT_W'(MAX_POINTS);
		end else begin
			n_sat = CNT_W'(pc_q);
		end
	end

	// ---------------------------------------------------------------
	// request side
	// ---------------------------------------------------------------
	assign in_xfer = in_valid && !in_stall;
	assign load_go = in_xfer && (req_type == REQ_LOAD);
	assign eval_go = in_xfer && (req_type == REQ_EVAL);

	// a slot beyond the store is dropped
	always_ff @(posedge clk) begin
		if (load_go && ({1'b0, point_index} < (IDX_W+1)'(MAX_POINTS))) begin
			store_x_q[point_index] <= coord_x;
			store_y_q[point_index] <= coord_y;
		end
	end

	// ---------------------------------------------------------------
	// sequencer: one lerp per step, a step only when the output slot frees
	// ---------------------------------------------------------------
	assign first     = (step_q == '0);
	assign level_end = (step_q == len_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b0;
		advance  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (eval_go) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				in_stall = 1'b1;
				advance  = !out_valid_q || !out_stall;
				if (advance && level_end && (len_q == LVL_W'(1))) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (eval_go) begin
			cur_level_q <= LVL_W'(1);
			len_q       <= LVL_W'(n_sat - 1'b1);
			step_q      <= '0;
			t_q         <= (t_param > T_ONE) ? T_ONE : t_param;
		end else if (advance) begin
			if (level_end) begin
				cur_level_q <= cur_level_q + 1'b1;
				len_q       <= len_q - 1'b1;
				step_q      <= '0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// cell chain: shifts toward cell 0, each new point lands at cell len
	// ---------------------------------------------------------------
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		cell_ctrl_t        ctrl;
		logic [2*PT_W-1:0] ld;
		logic [2*PT_W-1:0] nb1;
		logic [2*PT_W-1:0] nb2;

		assign ctrl.load  = eval_go;
		assign ctrl.step  = advance;
		assign ctrl.first = first;
		assign ctrl.ins   = ({1'b0, len_q} == (LVL_W+1)'(i));

		if (i == 0) begin : g_head
			assign ld = '0;
		end else begin : g_body
			assign ld = {store_x_q[i-1], {FRAC_BITS{1'b0}}, store_y_q[i-1], {FRAC_BITS{1'b0}}};
		end

		if (i + 1 < NCELL) begin : g_nb1
			assign nb1 = cell_pt[i+1];
		end else begin : g_nb1_end
			assign nb1 = '0;
		end

		if (i + 2 < NCELL) begin : g_nb2
			assign nb2 = cell_pt[i+2];
		end else begin : g_nb2_end
			assign nb2 = '0;
		end

		bdc_cell #(
			.PT_W(PT_W)
		) u_cell (
			.clk (clk),
			.ctrl(ctrl),
			.ld  (ld),
			.nb1 (nb1),
			.nb2 (nb2),
			.res ({qx, qy}),
			.pt  (cell_pt[i])
		);
	end

	// operands: skip the stale head on the first step of a level
	assign a_pt = first ? cell_pt[1] : cell_pt[0];
	assign b_pt = first ? cell_pt[2] : cell_pt[1];

	bdc_lerp #(
		.PT_W  (PT_W),
		.T_BITS(T_BITS)
	) u_lerp_x (
		.a(a_pt[2*PT_W-1:PT_W]),
		.b(b_pt[2*PT_W-1:PT_W]),
		.t(t_q),
		.q(qx)
	);

	bdc_lerp #(
		.PT_W  (PT_W),
		.T_BITS(T_BITS)
	) u_lerp_y (
		.a(a_pt[PT_W-1:0]),
		.b(b_pt[PT_W-1:0]),
		.t(t_q),
		.q(qy)
	);

	// ---------------------------------------------------------------
	// output register, filled on every step
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_level_q <= cur_level_q;
			out_pos_q   <= step_q;
			out_x_q     <= qx;
			out_y_q     <= qy;
			out_last_q  <= level_end && (len_q == LVL_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign level     = out_level_q;
	assign position  = out_pos_q;
	assign point_x   = out_x_q;
	assign point_y   = out_y_q;
	assign last      = out_last_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	a_step_in_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (step_q < len_q))
		else $error("step index beyond level length");

	a_level_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> ((CNT_W'(cur_level_q) + CNT_W'(len_q)) == n_sat))
		else $error("level and level length out of step");

	a_eval_start: assert property (@(posedge clk) disable iff (!arst_n)
		eval_go |=> (state_q == ST_RUN) && (cur_level_q == LVL_W'(1)) && (step_q == '0))
		else $error("evaluation did not start at level one");

	a_final_point: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && level_end && (len_q == LVL_W'(1))) |=>
		(state_q == ST_IDLE) && out_valid_q && out_last_q)
		else $error("curve point not flagged last or sequencer still busy");

endmodule
